### sv/multilevel_queue_schedule_sim_core_assert.svh
// =============================================================================
// Assertion macros for the multilevel queue scheduler
// Short forms for clocked, reset-qualified concurrent assertions.
// =============================================================================
`ifndef MULTILEVEL_QUEUE_SCHEDULE_SIM_CORE_ASSERT_SVH
`define MULTILEVEL_QUEUE_SCHEDULE_SIM_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLQ_ASSERT_SAME(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("mlq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MLQ_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("mlq assertion failed");

`endif

### sv/mlq_sched_pkg.sv
// =============================================================================
// Multilevel queue scheduler package
// Shared constants and word types for the scheduler core.
// =============================================================================
package mlq_sched_pkg;

   // The result limit caps how many records one batch can hold.
   localparam int RESULT_LIMIT = 16;
   localparam int ID_W         = 16;
   localparam int TIME_W       = 16;
   localparam int LVL_W        = 2;
   localparam int CLK_W        = 24;

   // One stored process record.
   typedef struct packed {
      logic [ID_W-1:0]   proc_id;
      logic [TIME_W-1:0] arrive_tick;
      logic [TIME_W-1:0] run_ticks;
      logic [LVL_W-1:0]  level;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // One result word.
   typedef struct packed {
      logic [ID_W-1:0]  out_id;
      logic [LVL_W-1:0] out_level;
      logic [CLK_W-1:0] turnaround;
      logic [CLK_W-1:0] waiting;
      logic             overflow;
      logic             last_result;
   } rsp_word_type;

endpackage

### sv/mlq_ram.sv
// =============================================================================
// Scheduler RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// =============================================================================
module mlq_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/mlq_out_stage.sv
// =============================================================================
// Scheduler result stage
// Holds one result word toward the response channel.
// =============================================================================
module mlq_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  mlq_sched_pkg::rsp_word_type word_in,
   output logic                       can_load,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [15:0]                rsp_out_id,
   output logic [1:0]                 rsp_out_level,
   output logic [23:0]                rsp_turnaround,
   output logic [23:0]                rsp_waiting,
   output logic                       rsp_overflow,
   output logic                       rsp_last_result
);

   logic                        valid_ff;
   mlq_sched_pkg::rsp_word_type word_ff;

   // A new word may enter when the stage is empty or its word leaves now.
   assign can_load = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_id      = word_ff.out_id;
   assign rsp_out_level   = word_ff.out_level;
   assign rsp_turnaround  = word_ff.turnaround;
   assign rsp_waiting     = word_ff.waiting;
   assign rsp_overflow    = word_ff.overflow;
   assign rsp_last_result = word_ff.last_result;

endmodule

### sv/multilevel_queue_schedule_sim_core.sv
// =============================================================================
// Multilevel queue scheduler core
// Loads process records, orders them per level, simulates the schedule and
// returns turnaround and waiting per process.
// =============================================================================
// Loading takes one record per cycle while idle. After the last record the core
// sorts by selection (a read and a compare state per candidate), then simulates
// rounds (order read, record and remaining-time read, service per entry), then
// emits the results in order, each waiting while the output stage is full. No record
// is taken from the last record until the last result enters the output register.
// Reset (synchronous, active high) empties the batch and sets the quantum to 4.
module multilevel_queue_schedule_sim_core #(
   parameter int MAX_PROCS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_proc_id,
   input  logic [15:0] req_arrive_tick,
   input  logic [15:0] req_run_ticks,
   input  logic [1:0]  req_level,
   input  logic        req_last_record,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_out_id,
   output logic [1:0]  rsp_out_level,
   output logic [23:0] rsp_turnaround,
   output logic [23:0] rsp_waiting,
   output logic        rsp_overflow,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_rr_quantum
);

   `include "multilevel_queue_schedule_sim_core_assert.svh"

   localparam int CAP   = (MAX_PROCS < mlq_sched_pkg::RESULT_LIMIT) ?
                          MAX_PROCS : mlq_sched_pkg::RESULT_LIMIT;
   localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int CNT_W = $clog2(CAP + 1);
   localparam int KEY_W = mlq_sched_pkg::LVL_W + mlq_sched_pkg::TIME_W + IDX_W;
   localparam int CLK_W = mlq_sched_pkg::CLK_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SIM_ROUND,
      ST_SIM_ORD,
      ST_SIM_REC,
      ST_SIM_EXE,
      ST_SIM_END,
      ST_OUT_RD,
      ST_OUT_REC,
      ST_OUT_WR
   } state_type;

   state_type            state_ff;
   logic [15:0]          quantum_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 overflow_ff;
   logic [CNT_W-1:0]     i_ff;
   logic [CNT_W-1:0]     pos_ff;
   logic [CNT_W-1:0]     k_ff;
   logic [KEY_W-1:0]     prev_ff;
   logic                 have_prev_ff;
   logic [KEY_W-1:0]     best_ff;
   logic                 best_valid_ff;
   logic [CLK_W-1:0]     clk_ff;
   logic                 ran_ff;
   logic [CNT_W-1:0]     done_cnt_ff;
   logic [CAP-1:0]       done_ff;
   logic [IDX_W-1:0]     e_ff;

   // RAM ports.
   logic                        rec_re;
   logic [IDX_W-1:0]            rec_raddr;
   mlq_sched_pkg::rec_type      rec_wdata;
   mlq_sched_pkg::rec_type      rec_rdata;
   logic                        rem_we;
   logic [IDX_W-1:0]            rem_waddr;
   logic [15:0]                 rem_wdata;
   logic                        rem_re;
   logic [15:0]                 rem_rdata;
   logic                        fin_we;
   logic                        fin_re;
   logic [CLK_W-1:0]            fin_rdata;
   logic                        ord_we;
   logic                        ord_re;
   logic [IDX_W-1:0]            ord_rdata;

   logic                        accept;
   logic                        store;
   logic                        out_can_load;
   logic                        out_load;
   mlq_sched_pkg::rsp_word_type out_word;

   // Sort datapath.
   logic [KEY_W-1:0]            cand_key;
   logic                        cand_ok;
   logic [KEY_W-1:0]            win_key;
   logic [CNT_W-1:0]            i_next;
   logic [CNT_W-1:0]            pos_next;
   logic [CNT_W-1:0]            k_next;

   // Simulation datapath.
   logic [15:0]                 q_eff;
   logic                        eligible;
   logic                        slice;
   logic [15:0]                 step;
   logic [CLK_W-1:0]            clk_step;
   logic [CLK_W-1:0]            tat;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign store     = accept && (count_ff < CNT_W'(CAP));

   assign i_next   = i_ff + 1'b1;
   assign pos_next = pos_ff + 1'b1;
   assign k_next   = k_ff + 1'b1;

   // Record fields written at load.
   always_comb begin
      rec_wdata.proc_id     = req_proc_id;
      rec_wdata.arrive_tick = req_arrive_tick;
      rec_wdata.run_ticks   = req_run_ticks;
      rec_wdata.level       = req_level;
   end

   // Read address selection by phase.
   always_comb begin
      rec_re    = 1'b0;
      rec_raddr = ord_rdata;
      rem_re    = 1'b0;
      fin_re    = 1'b0;
      ord_re    = 1'b0;
      unique case (state_ff)
         ST_SORT_RD: begin
            rec_re    = 1'b1;
            rec_raddr = i_ff[IDX_W-1:0];
         end
         ST_SIM_ORD, ST_OUT_RD: begin
            ord_re = 1'b1;
         end
         ST_SIM_REC: begin
            rec_re = 1'b1;
            rem_re = 1'b1;
         end
         ST_OUT_REC: begin
            rec_re = 1'b1;
            fin_re = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Sort key: shortest burst for levels one and two, arrival otherwise.
   // The level and the load index complete a total order that keeps ties stable.
   always_comb begin
      if ((rec_rdata.level == 2'd1) || (rec_rdata.level == 2'd2)) begin
         cand_key = {rec_rdata.level, rec_rdata.run_ticks, i_ff[IDX_W-1:0]};
      end else begin
         cand_key = {rec_rdata.level, rec_rdata.arrive_tick, i_ff[IDX_W-1:0]};
      end
      cand_ok = (!have_prev_ff || (cand_key > prev_ff)) &&
                (!best_valid_ff || (cand_key < best_ff));
      win_key = cand_ok ? cand_key : best_ff;
   end

   assign ord_we = (state_ff == ST_SORT_CMP) && (i_next == count_ff);

   // One service turn of the entry under examination.
   always_comb begin
      q_eff    = (quantum_ff == 16'd0) ? 16'd1 : quantum_ff;
      eligible = !done_ff[e_ff] &&
                 ({8'd0, rec_rdata.arrive_tick} <= clk_ff);
      slice    = (rec_rdata.level == 2'd0) && (rem_rdata > q_eff);
      step     = slice ? q_eff : rem_rdata;
      clk_step = clk_ff + {8'd0, step};
   end

   // Remaining-time writes come from loading or from a service turn.
   always_comb begin
      if (state_ff == ST_SIM_EXE) begin
         rem_we    = eligible;
         rem_waddr = e_ff;
         rem_wdata = slice ? (rem_rdata - q_eff) : 16'd0;
      end else begin
         rem_we    = store;
         rem_waddr = count_ff[IDX_W-1:0];
         rem_wdata = req_run_ticks;
      end
   end

   assign fin_we = (state_ff == ST_SIM_EXE) && eligible && !slice;

   // Result word.
   always_comb begin
      tat                  = fin_rdata - {8'd0, rec_rdata.arrive_tick};
      out_word.out_id      = rec_rdata.proc_id;
      out_word.out_level   = rec_rdata.level;
      out_word.turnaround  = tat;
      out_word.waiting     = tat - {8'd0, rec_rdata.run_ticks};
      out_word.overflow    = overflow_ff;
      out_word.last_result = (k_next == count_ff);
   end

   assign out_load = (state_ff == ST_OUT_WR) && out_can_load;

   // Controller.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         quantum_ff    <= 16'd4;
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         i_ff          <= '0;
         pos_ff        <= '0;
         k_ff          <= '0;
         have_prev_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         clk_ff        <= '0;
         ran_ff        <= 1'b0;
         done_cnt_ff   <= '0;
         done_ff       <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  quantum_ff <= csr_rr_quantum;
               end
               if (accept) begin
                  if (store) begin
                     count_ff                        <= count_ff + 1'b1;
                     done_ff[count_ff[IDX_W-1:0]]    <= 1'b0;
                  end else begin
                     overflow_ff <= 1'b1;
                  end
                  if (req_last_record) begin
                     state_ff      <= ST_SORT_RD;
                     i_ff          <= '0;
                     pos_ff        <= '0;
                     have_prev_ff  <= 1'b0;
                     best_valid_ff <= 1'b0;
                  end
               end
            end
            ST_SORT_RD: begin
               state_ff <= ST_SORT_CMP;
            end
            ST_SORT_CMP: begin
               // Selection sort: each pass picks the next key above the last one.
               if (i_next == count_ff) begin
                  prev_ff       <= win_key;
                  have_prev_ff  <= 1'b1;
                  best_valid_ff <= 1'b0;
                  i_ff          <= '0;
                  pos_ff        <= pos_next;
                  state_ff      <= (pos_next == count_ff) ? ST_SIM_ROUND : ST_SORT_RD;
               end else begin
                  best_ff       <= win_key;
                  best_valid_ff <= best_valid_ff || cand_ok;
                  i_ff          <= i_next;
                  state_ff      <= ST_SORT_RD;
               end
            end
            ST_SIM_ROUND: begin
               k_ff   <= '0;
               ran_ff <= 1'b0;
               state_ff <= (done_cnt_ff == count_ff) ? ST_OUT_RD : ST_SIM_ORD;
            end
            ST_SIM_ORD: begin
               state_ff <= ST_SIM_REC;
            end
            ST_SIM_REC: begin
               e_ff     <= ord_rdata;
               state_ff <= ST_SIM_EXE;
            end
            ST_SIM_EXE: begin
               if (eligible) begin
                  ran_ff <= 1'b1;
                  clk_ff <= clk_step;
                  if (!slice) begin
                     done_ff[e_ff] <= 1'b1;
                     done_cnt_ff   <= done_cnt_ff + 1'b1;
                  end
               end
               k_ff     <= k_next;
               state_ff <= (k_next == count_ff) ? ST_SIM_END : ST_SIM_ORD;
            end
            ST_SIM_END: begin
               // An idle round advances the clock by one tick.
               if (!ran_ff) begin
                  clk_ff <= clk_ff + 1'b1;
               end
               state_ff <= ST_SIM_ROUND;
            end
            ST_OUT_RD: begin
               state_ff <= ST_OUT_REC;
            end
            ST_OUT_REC: begin
               state_ff <= ST_OUT_WR;
            end
            ST_OUT_WR: begin
               if (out_load) begin
                  k_ff <= k_next;
                  if (k_next == count_ff) begin
                     // Batch finished: return to an empty table.
                     state_ff    <= ST_IDLE;
                     count_ff    <= '0;
                     overflow_ff <= 1'b0;
                     clk_ff      <= '0;
                     done_cnt_ff <= '0;
                     done_ff     <= '0;
                  end else begin
                     state_ff <= ST_OUT_RD;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   mlq_ram #(
      .WIDTH  (mlq_sched_pkg::REC_W),
      .DEPTH  (CAP),
      .ADDR_W (IDX_W)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (rec_wdata),
      .rd_en   (rec_re),
      .rd_addr (rec_raddr),
      .rd_data (rec_rdata)
   );

   mlq_ram #(
      .WIDTH  (16),
      .DEPTH  (CAP),
      .ADDR_W (IDX_W)
   ) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_we),
      .wr_addr (rem_waddr),
      .wr_data (rem_wdata),
      .rd_en   (rem_re),
      .rd_addr (ord_rdata),
      .rd_data (rem_rdata)
   );

   mlq_ram #(
      .WIDTH  (CLK_W),
      .DEPTH  (CAP),
      .ADDR_W (IDX_W)
   ) u_fin_ram (
      .clock   (clock),
      .wr_en   (fin_we),
      .wr_addr (e_ff),
      .wr_data (clk_step),
      .rd_en   (fin_re),
      .rd_addr (ord_rdata),
      .rd_data (fin_rdata)
   );

   mlq_ram #(
      .WIDTH  (IDX_W),
      .DEPTH  (CAP),
      .ADDR_W (IDX_W)
   ) u_ord_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (pos_ff[IDX_W-1:0]),
      .wr_data (win_key[IDX_W-1:0]),
      .rd_en   (ord_re),
      .rd_addr (k_ff[IDX_W-1:0]),
      .rd_data (ord_rdata)
   );

   mlq_out_stage u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .load            (out_load),
      .word_in         (out_word),
      .can_load        (out_can_load),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_level   (rsp_out_level),
      .rsp_turnaround  (rsp_turnaround),
      .rsp_waiting     (rsp_waiting),
      .rsp_overflow    (rsp_overflow),
      .rsp_last_result (rsp_last_result)
   );

   // The finished count tracks the done flags.
   `MLQ_ASSERT_SAME(a_done_count, clock, reset, 1'b1, $countones(done_ff) == int'(done_cnt_ff))
   // A stalled result word stays valid with its id and turnaround unchanged.
   `MLQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_id) && $stable(rsp_turnaround))
   // A record that ends the batch closes the input until the results are out.
   `MLQ_ASSERT_NEXT(a_last_closes, clock, reset, accept && req_last_record, req_stall)

endmodule

### tb/multilevel_queue_schedule_sim_core_tb.sv
// =============================================================================
// Multilevel queue scheduler core testbench
// Feeds process records in batches at several quantum settings. An internal
// scheduler predicts every result word, which is checked field by field.
// =============================================================================
module multilevel_queue_schedule_sim_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] proc_id;
      logic [15:0] arrive_tick;
      logic [15:0] run_ticks;
      logic [1:0]  level;
      logic        last_record;
   } proc_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_proc_id;
   logic [15:0] req_arrive_tick;
   logic [15:0] req_run_ticks;
   logic [1:0]  req_level;
   logic        req_last_record;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_out_id;
   logic [1:0]  rsp_out_level;
   logic [23:0] rsp_turnaround;
   logic [23:0] rsp_waiting;
   logic        rsp_overflow;
   logic        rsp_last_result;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_rr_quantum;

   proc_word_type               pending_procs[$];
   mlq_sched_pkg::rsp_word_type expected_results[$];
   int            fail_count = 0;
   bit            quiet = 0;
   int            hold_gen = 0;

   // Predictor state: the batch being loaded and the quantum in force.
   logic [15:0] quantum_cfg;
   logic [15:0] b_id[mlq_sched_pkg::RESULT_LIMIT];
   logic [15:0] b_arr[mlq_sched_pkg::RESULT_LIMIT];
   logic [15:0] b_burst[mlq_sched_pkg::RESULT_LIMIT];
   logic [1:0]  b_lvl[mlq_sched_pkg::RESULT_LIMIT];
   int          b_cnt;
   bit          b_ovf;

   multilevel_queue_schedule_sim_core #(.MAX_PROCS(16)) u_dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("status: fail");
      $finish;
   end

   function automatic int sort_key(int i, int lv);
      return (lv == 1 || lv == 2) ? int'(b_burst[i]) : int'(b_arr[i]);
   endfunction

   // Orders the batch per level, simulates the rounds and queues the results.
   task automatic schedule_batch();
      int ord[mlq_sched_pkg::RESULT_LIMIT];
      int st[4];
      int cn[4];
      int fdone[4];
      int rem[mlq_sched_pkg::RESULT_LIMIT];
      bit dn[mlq_sched_pkg::RESULT_LIMIT];
      int fin_t[mlq_sched_pkg::RESULT_LIMIT];
      int pos, j, k, clk, q, e;
      bit ran;
      mlq_sched_pkg::rsp_word_type w;
      logic [23:0] tat;
      pos = 0;
      for (int lv = 0; lv < 4; lv++) begin
         st[lv] = pos;
         for (int i = 0; i < b_cnt; i++) begin
            if (b_lvl[i] == lv) begin
               j = pos;
               k = sort_key(i, lv);
               while (j > st[lv] && sort_key(ord[j-1], lv) > k) begin
                  ord[j] = ord[j-1];
                  j--;
               end
               ord[j] = i;
               pos++;
            end
         end
         cn[lv] = pos - st[lv];
         fdone[lv] = 0;
      end
      for (int i = 0; i < b_cnt; i++) begin
         rem[i] = b_burst[i];
         dn[i] = 0;
      end
      q = (quantum_cfg == 0) ? 1 : int'(quantum_cfg);
      clk = 0;
      while (fdone[0] < cn[0] || fdone[1] < cn[1] || fdone[2] < cn[2] || fdone[3] < cn[3]) begin
         ran = 0;
         for (int lv = 0; lv < 4; lv++) begin
            if (fdone[lv] < cn[lv]) begin
               for (int p = 0; p < cn[lv]; p++) begin
                  e = ord[st[lv] + p];
                  if (!dn[e] && int'(b_arr[e]) <= clk) begin
                     ran = 1;
                     if (lv == 0 && rem[e] > q) begin
                        clk += q;
                        rem[e] -= q;
                     end else begin
                        clk += rem[e];
                        rem[e] = 0;
                        dn[e] = 1;
                        fin_t[e] = clk;
                        fdone[lv]++;
                     end
                  end
               end
            end
         end
         if (!ran) clk++;
      end
      for (int n = 0; n < b_cnt; n++) begin
         e = ord[n];
         tat = 24'(fin_t[e] - int'(b_arr[e]));
         w.out_id      = b_id[e];
         w.out_level   = b_lvl[e];
         w.turnaround  = tat;
         w.waiting     = tat - 24'(b_burst[e]);
         w.overflow    = b_ovf;
         w.last_result = (n == b_cnt - 1);
         expected_results.push_back(w);
      end
      b_cnt = 0;
      b_ovf = 0;
   endtask

   // Takes one accepted record into the batch; the last one runs the batch.
   task automatic load_record(proc_word_type r);
      if (b_cnt < mlq_sched_pkg::RESULT_LIMIT) begin
         b_id[b_cnt]    = r.proc_id;
         b_arr[b_cnt]   = r.arrive_tick;
         b_burst[b_cnt] = r.run_ticks;
         b_lvl[b_cnt]   = r.level;
         b_cnt++;
      end else begin
         b_ovf = 1;
      end
      if (r.last_record) schedule_batch();
   endtask

   // Driver: presents pending records, with random idle bursts between words.
   int gap = 0;
   always @(posedge clock) begin
      proc_word_type r;
      if (reset) begin
         req_valid <= 0;
         gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            r.proc_id     = req_proc_id;
            r.arrive_tick = req_arrive_tick;
            r.run_ticks   = req_run_ticks;
            r.level       = req_level;
            r.last_record = req_last_record;
            load_record(r);
         end
         if (!req_valid || !req_stall) begin
            if (gap > 0) begin
               gap--;
               req_valid <= 0;
            end else if (pending_procs.size() > 0) begin
               r = pending_procs.pop_front();
               req_valid       <= 1;
               req_proc_id     <= r.proc_id;
               req_arrive_tick <= r.arrive_tick;
               req_run_ticks   <= r.run_ticks;
               req_level       <= r.level;
               req_last_record <= r.last_record;
               if (!quiet && $urandom_range(0, 11) == 0) gap = $urandom_range(1, 18);
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // Monitor: checks each accepted result word and drives the stall.
   int stall_cnt = 0;
   int seen_gen = 0;
   always @(posedge clock) begin
      mlq_sched_pkg::rsp_word_type w;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result word id %h", $time, rsp_out_id);
               fail_count++;
            end else begin
               w = expected_results.pop_front();
               if (w.out_id !== rsp_out_id || w.out_level !== rsp_out_level ||
                   w.turnaround !== rsp_turnaround || w.waiting !== rsp_waiting ||
                   w.overflow !== rsp_overflow || w.last_result !== rsp_last_result) begin
                  $display("%0t: mismatch expected id %h lvl %0d tat %0d wt %0d ovf %b last %b",
                           $time, w.out_id, w.out_level, w.turnaround, w.waiting,
                           w.overflow, w.last_result);
                  $display("%0t:          actual id %h lvl %0d tat %0d wt %0d ovf %b last %b",
                           $time, rsp_out_id, rsp_out_level, rsp_turnaround, rsp_waiting,
                           rsp_overflow, rsp_last_result);
                  fail_count++;
               end
            end
         end
         if (seen_gen != hold_gen) begin
            seen_gen = hold_gen;
            stall_cnt = 400;
         end
         if (stall_cnt > 0) begin
            stall_cnt--;
            rsp_stall <= 1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_cnt = $urandom_range(0, 17);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   task automatic add_proc(int id, int arr, int burst, int lv, bit last);
      proc_word_type r;
      r.proc_id     = 16'(id);
      r.arrive_tick = 16'(arr);
      r.run_ticks   = 16'(burst);
      r.level       = 2'(lv);
      r.last_record = last;
      pending_procs.push_back(r);
   endtask

   // Waits until every word is out and answered, then lets the core settle.
   task automatic wait_idle();
      while (pending_procs.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_quantum(logic [15:0] v);
      @(posedge clock);
      csr_valid      <= 1;
      csr_rr_quantum <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      quantum_cfg = v;
      csr_valid <= 0;
   endtask

   // One random batch; now and then it runs past capacity.
   task automatic random_batch(int q);
      int n, lv, burst;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
         lv = $urandom_range(0, 3);
         if (lv == 0) burst = $urandom_range(0, (q == 0 || q == 1) ? 24 : 40);
         else if ($urandom_range(0, 9) == 0) burst = $urandom_range(0, 65535);
         else burst = $urandom_range(0, 50);
         add_proc($urandom_range(0, 65535), $urandom_range(0, 40), burst, lv, i == n - 1);
      end
   endtask

   initial begin
      int qs[6];
      quantum_cfg     = 4;
      b_cnt           = 0;
      b_ovf           = 0;
      reset           = 1;
      req_valid       = 0;
      req_proc_id     = 0;
      req_arrive_tick = 0;
      req_run_ticks   = 0;
      req_level       = 0;
      req_last_record = 0;
      rsp_stall       = 0;
      csr_valid       = 0;
      csr_rr_quantum  = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // Directed: every level, ties, zero burst, extreme ids and bursts.
      add_proc(16'h0000, 0, 10, 0, 0);
      add_proc(16'hFFFF, 0, 10, 0, 0);
      add_proc(16'h1234, 2, 0, 0, 0);
      add_proc(16'h2222, 0, 7, 1, 0);
      add_proc(16'h3333, 1, 7, 1, 0);
      add_proc(16'h4444, 0, 65535, 2, 0);
      add_proc(16'h5555, 3, 0, 2, 0);
      add_proc(16'h6666, 5, 3, 3, 0);
      add_proc(16'h7777, 5, 2, 3, 1);
      wait_idle();
      // A late arrival alone forces idle ticks up to the top of the range.
      add_proc(16'hAAAA, 65535, 1, 3, 1);
      wait_idle();
      write_quantum(16'hFFFF);
      add_proc(16'h5A5A, 0, 65535, 0, 0);
      add_proc(16'hA5A5, 1, 65535, 0, 1);
      wait_idle();
      // A zero quantum behaves as one.
      write_quantum(16'h0000);
      add_proc(16'h0101, 0, 3, 0, 0);
      add_proc(16'h0202, 0, 2, 0, 0);
      add_proc(16'h0303, 1, 0, 3, 1);
      wait_idle();

      // Random phases over several quantum settings.
      qs[0] = 1;
      qs[1] = 65535;
      qs[2] = 0;
      qs[3] = $urandom_range(2, 8);
      qs[4] = $urandom_range(1, 65535);
      qs[5] = 4;
      for (int ph = 0; ph < 6; ph++) begin
         write_quantum(16'(qs[ph]));
         if (ph == 5) quiet = 1;
         if (ph == 2) hold_gen++;
         while (pending_procs.size() < 62) random_batch(qs[ph]);
         wait_idle();
      end
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/mlq_sched_pkg.sv
sv/mlq_ram.sv
sv/mlq_out_stage.sv
sv/multilevel_queue_schedule_sim_core.sv
tb/multilevel_queue_schedule_sim_core_tb.sv
